[hdl/pov_column_led_frame_streamer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the POV column streamer checker
// Each use expands to one labeled concurrent assertion on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef POV_COLUMN_LED_FRAME_STREAMER_ASSERT_SVH
`define POV_COLUMN_LED_FRAME_STREAMER_ASSERT_SVH

// same-cycle implication
`define POVCOL_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POVCOL_AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/povcol_pkg.sv]
// ----------------------------------------------------------------------------
// povcol_pkg
// Shared types, codes and the gamma table of the POV column streamer.
// ----------------------------------------------------------------------------
`default_nettype none

package povcol_pkg;

  // default storage bounds
  localparam int DEF_MAX_LEDS    = 32;
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_FRAMES  = 8;

  // store address as carried in a request, wide enough for the largest store
  localparam int ADDR_MAX_W = 22;

  // input opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_BLANK = 2'd2;

  // request kinds between front and back
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_BLANK = 2'd2;

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REVS_PER_FRAME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 2'd3;

  localparam logic [5:0] RST_LED_COUNT      = 6'd32;
  localparam logic [6:0] RST_COLUMN_COUNT   = 7'd64;
  localparam logic [7:0] RST_REVS_PER_FRAME = 8'd1;
  localparam logic [3:0] RST_FRAME_COUNT    = 4'd1;

  // strip word framing
  localparam logic [31:0] WORD_START = 32'h0000_0000;
  localparam logic [31:0] WORD_END   = 32'hFFFF_FFFF;
  localparam logic [7:0]  LED_MARK   = 8'hFF;

  // queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic [1:0]            kind;
    logic [ADDR_MAX_W-1:0] addr;
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // gamma: floor(c^3 / 255^2), built at elaboration
  localparam int unsigned GammaDiv = 255 * 255;

  typedef logic [255:0][7:0] gamma_lut_t;

  function automatic gamma_lut_t build_gamma_lut();
    gamma_lut_t  lut;
    int unsigned c;
    for (int i = 0; i < 256; i++) begin
      c      = i;
      lut[i] = 8'((c * c * c) / GammaDiv);
    end
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

endpackage

`default_nettype wire

[hdl/povcol_front.sv]
// ----------------------------------------------------------------------------
// povcol_front
// Decodes input items into requests and computes the pixel store address.
// ----------------------------------------------------------------------------
`default_nettype none

module povcol_front import povcol_pkg::*; #(
  parameter int MAX_LEDS    = DEF_MAX_LEDS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
  input  logic       push,
  input  logic [1:0] op,
  input  logic [4:0] led_index,
  input  logic [5:0] column_index,
  input  logic [2:0] frame_index,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int unsigned COL_STRIDE = MAX_LEDS;
  localparam int unsigned FRM_STRIDE = MAX_LEDS * MAX_COLUMNS;

  logic in_range;
  logic keep;

  // check write position against the store bounds
  assign in_range = (32'(led_index) < 32'(MAX_LEDS)) &&
                    (32'(column_index) < 32'(MAX_COLUMNS)) &&
                    (32'(frame_index) < 32'(MAX_FRAMES));

  // classify and build the request; drop unused opcodes and stray writes
  always_comb begin
    q_cmd.addr  = ADDR_MAX_W'(32'(led_index) + 32'(column_index) * COL_STRIDE +
                              32'(frame_index) * FRM_STRIDE);
    q_cmd.blue  = blue;
    q_cmd.green = green;
    q_cmd.red   = red;
    q_cmd.kind  = CMD_WRITE;
    keep        = 1'b0;
    unique case (op)
      OP_WRITE: begin
        q_cmd.kind = CMD_WRITE;
        keep       = in_range;
      end
      OP_TICK: begin
        q_cmd.kind = CMD_TICK;
        keep       = 1'b1;
      end
      OP_BLANK: begin
        q_cmd.kind = CMD_BLANK;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = push && !q_full && keep;

endmodule

`default_nettype wire

[hdl/povcol_queue.sv]
// ----------------------------------------------------------------------------
// povcol_queue
// Short request queue that decouples the front decoder from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module povcol_queue import povcol_pkg::*; #(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (32'(p) == 32'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (32'(cnt_r) == 32'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries_r[rd_ptr_r];

  // advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = do_push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? bump(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold request payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

[hdl/povcol_back.sv]
// ----------------------------------------------------------------------------
// povcol_back
// Pixel store, column sequencer, gamma stage and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module povcol_back import povcol_pkg::*; #(
  parameter int MAX_LEDS    = DEF_MAX_LEDS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_wr_t     cfg_wr,
  input  logic        cmd_empty,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_led_word,
  output logic        out_last_word
);

  localparam int DEPTH    = MAX_LEDS * MAX_COLUMNS * MAX_FRAMES;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int FRM_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int ECW      = $clog2(MAX_COLUMNS + 1);
  localparam int ELW      = $clog2(MAX_LEDS + 1);
  localparam int IDX_W    = $clog2(MAX_LEDS + 2);
  localparam int XW       = FRM_W + 1;
  localparam int STEP_W   = $clog2(XW);
  localparam int OQ_PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned COL_STRIDE = MAX_LEDS;
  localparam int unsigned FRM_STRIDE = MAX_LEDS * MAX_COLUMNS;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;

  // word kinds
  localparam logic [1:0] WK_START = 2'd0;
  localparam logic [1:0] WK_LED   = 2'd1;
  localparam logic [1:0] WK_END   = 2'd2;

  function automatic logic [ECW-1:0] clamp_cols(input logic [6:0] v);
    if (v == '0) return ECW'(1);
    if (32'(v) > 32'(MAX_COLUMNS)) return ECW'(MAX_COLUMNS);
    return ECW'(v);
  endfunction

  function automatic logic [XW-1:0] clamp_frames(input logic [3:0] v);
    if (v == '0) return XW'(1);
    if (32'(v) > 32'(MAX_FRAMES)) return XW'(MAX_FRAMES);
    return XW'(v);
  endfunction

  function automatic logic [ELW-1:0] clamp_leds(input logic [5:0] v);
    if (32'(v) > 32'(MAX_LEDS)) return ELW'(MAX_LEDS);
    return ELW'(v);
  endfunction

  function automatic logic [OQ_PTR_W-1:0] oq_bump(input logic [OQ_PTR_W-1:0] p);
    return (32'(p) == 32'(OUTQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration and position state
  logic [5:0]        led_count_r, led_count_nxt;
  logic [6:0]        column_count_r, column_count_nxt;
  logic [7:0]        revs_r, revs_nxt;
  logic [3:0]        frame_count_r, frame_count_nxt;
  logic [COL_W-1:0]  column_pos_r, column_pos_nxt;
  logic [7:0]        rev_r, rev_nxt;
  logic [FRM_W-1:0]  frame_pos_r, frame_pos_nxt;

  // sequencer
  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              dark_r, dark_nxt;
  logic              tick_r, tick_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [XW-1:0]     x_r, x_nxt;
  logic [XW-1:0]     rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // read stage
  logic              s1_valid_r;
  logic [1:0]        s1_kind_r;
  logic              s1_dark_r;
  logic [23:0]       rd_data_r;
  logic [23:0]       store_r [DEPTH];

  // result queue
  logic [32:0]         oq_mem_r [OUTQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_ptr_r, oq_rd_ptr_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r;

  logic [ELW-1:0]    n_leds;
  logic [ECW-1:0]    ecols, ecols_cfg;
  logic [XW-1:0]     efrm;
  logic              slot_ok, is_start, is_end;
  logic [ADDR_W-1:0] led_addr;
  logic              cp_wrap, adv;
  logic [COL_W-1:0]  cp_step;
  logic [7:0]        rev_inc;
  logic [XW:0]       rem_sh, rem_new;
  logic              mem_we, mem_re, iss_valid;
  logic [1:0]        iss_kind;
  logic [32:0]       s1_entry;
  logic              oq_pop;

  assign n_leds    = clamp_leds(led_count_r);
  assign ecols     = clamp_cols(column_count_r);
  assign ecols_cfg = clamp_cols(cfg_wr.data[6:0]);
  assign efrm      = clamp_frames(frame_count_r);

  // room for one more word, counting the one in the read stage
  assign slot_ok = s1_valid_r ? (32'(oq_cnt_r) < 32'(OUTQ_DEPTH - 1))
                              : (32'(oq_cnt_r) < 32'(OUTQ_DEPTH));
  assign is_start = (idx_r == '0);
  assign is_end   = (32'(idx_r) > 32'(n_leds));
  assign led_addr = base_r + ADDR_W'(idx_r - 1'b1);

  // column countdown, revolution count and frame advance decision
  assign cp_wrap = (column_pos_r == '0) || (32'(column_pos_r) >= 32'(ecols));
  assign cp_step = cp_wrap ? COL_W'(ecols - 1'b1) : column_pos_r - 1'b1;
  assign rev_inc = rev_r + ((cp_step == '0) ? 8'd1 : 8'd0);
  assign adv     = (rev_inc == revs_r);

  // one restoring remainder step for the frame wrap
  assign rem_sh  = {rem_r, x_r[XW-1]};
  assign rem_new = (rem_sh >= (XW+1)'(efrm)) ? rem_sh - (XW+1)'(efrm) : rem_sh;

  always_comb begin
    led_count_nxt    = led_count_r;
    column_count_nxt = column_count_r;
    revs_nxt         = revs_r;
    frame_count_nxt  = frame_count_r;
    column_pos_nxt   = column_pos_r;
    rev_nxt          = rev_r;
    frame_pos_nxt    = frame_pos_r;
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    dark_nxt         = dark_r;
    tick_nxt         = tick_r;
    base_nxt         = base_r;
    x_nxt            = x_r;
    rem_nxt          = rem_r;
    step_nxt         = step_r;
    cmd_pop          = 1'b0;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    iss_valid        = 1'b0;
    iss_kind         = WK_START;

    unique case (state_r)
      // take the next request
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_WRITE: mem_we = 1'b1;
            CMD_TICK, CMD_BLANK: begin
              state_nxt = ST_RUN;
              idx_nxt   = '0;
              dark_nxt  = (cmd.kind == CMD_BLANK);
              tick_nxt  = (cmd.kind == CMD_TICK);
              base_nxt  = ADDR_W'(32'(column_pos_r) * COL_STRIDE +
                                  32'(frame_pos_r) * FRM_STRIDE);
            end
            default: ;
          endcase
        end
      end
      // emit start word, LED words, end word
      ST_RUN: begin
        if (slot_ok) begin
          iss_valid = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          priority if (is_start) begin
            iss_kind = WK_START;
          end else if (is_end) begin
            iss_kind  = WK_END;
            state_nxt = ST_IDLE;
            if (tick_r) begin
              column_pos_nxt = cp_step;
              if (adv) begin
                rev_nxt   = 8'd0;
                x_nxt     = XW'(frame_pos_r) + 1'b1;
                rem_nxt   = '0;
                step_nxt  = STEP_W'(XW - 1);
                state_nxt = ST_MOD;
              end else begin
                rev_nxt = rev_inc;
              end
            end
          end else begin
            iss_kind = WK_LED;
            mem_re   = !dark_r;
          end
        end
      end
      // frame_pos = (frame_pos + 1) mod frames, one bit a cycle
      ST_MOD: begin
        x_nxt    = x_r << 1;
        rem_nxt  = XW'(rem_new);
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          frame_pos_nxt = FRM_W'(rem_new);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // register writes; column count reloads the position counters
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_LED_COUNT:      led_count_nxt = cfg_wr.data[5:0];
        REG_COLUMN_COUNT: begin
          column_count_nxt = cfg_wr.data[6:0];
          column_pos_nxt   = COL_W'(ecols_cfg - 1'b1);
          rev_nxt          = 8'd0;
          frame_pos_nxt    = '0;
        end
        REG_REVS_PER_FRAME: revs_nxt = cfg_wr.data;
        REG_FRAME_COUNT:    frame_count_nxt = cfg_wr.data[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r    <= RST_LED_COUNT;
      column_count_r <= RST_COLUMN_COUNT;
      revs_r         <= RST_REVS_PER_FRAME;
      frame_count_r  <= RST_FRAME_COUNT;
      column_pos_r   <= COL_W'(clamp_cols(RST_COLUMN_COUNT) - 1'b1);
      rev_r          <= 8'd0;
      frame_pos_r    <= '0;
      state_r        <= ST_IDLE;
      s1_valid_r     <= 1'b0;
    end else begin
      led_count_r    <= led_count_nxt;
      column_count_r <= column_count_nxt;
      revs_r         <= revs_nxt;
      frame_count_r  <= frame_count_nxt;
      column_pos_r   <= column_pos_nxt;
      rev_r          <= rev_nxt;
      frame_pos_r    <= frame_pos_nxt;
      state_r        <= state_nxt;
      s1_valid_r     <= iss_valid;
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    dark_r    <= dark_nxt;
    tick_r    <= tick_nxt;
    base_r    <= base_nxt;
    x_r       <= x_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    s1_kind_r <= iss_kind;
    s1_dark_r <= dark_r;
  end

  // pixel store: one write or one read a cycle, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[cmd.addr[ADDR_W-1:0]] <= {cmd.blue, cmd.green, cmd.red};
    end
    if (mem_re) begin
      rd_data_r <= store_r[led_addr];
    end
  end

  // build the strip word from the read stage
  always_comb begin
    unique case (s1_kind_r)
      WK_START: s1_entry = {WORD_START, 1'b0};
      WK_END:   s1_entry = {WORD_END, 1'b1};
      WK_LED: begin
        if (s1_dark_r) begin
          s1_entry = {LED_MARK, 24'd0, 1'b0};
        end else begin
          s1_entry = {LED_MARK, GAMMA_LUT[rd_data_r[23:16]],
                      GAMMA_LUT[rd_data_r[15:8]], GAMMA_LUT[rd_data_r[7:0]], 1'b0};
        end
      end
      default:  s1_entry = {WORD_END, 1'b1};
    endcase
  end

  // result queue
  assign out_empty     = (oq_cnt_r == '0);
  assign oq_pop        = out_pop && !out_empty;
  assign out_led_word  = oq_mem_r[oq_rd_ptr_r][32:1];
  assign out_last_word = oq_mem_r[oq_rd_ptr_r][0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_ptr_r <= '0;
      oq_rd_ptr_r <= '0;
      oq_cnt_r    <= '0;
    end else begin
      if (s1_valid_r) begin
        oq_wr_ptr_r <= oq_bump(oq_wr_ptr_r);
      end
      if (oq_pop) begin
        oq_rd_ptr_r <= oq_bump(oq_rd_ptr_r);
      end
      oq_cnt_r <= oq_cnt_r + OQ_CNT_W'(s1_valid_r) - OQ_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      oq_mem_r[oq_wr_ptr_r] <= s1_entry;
    end
  end

endmodule

`default_nettype wire

[hdl/pov_column_led_frame_streamer.sv]
// ----------------------------------------------------------------------------
// pov_column_led_frame_streamer
// POV column driver: stores RGB pixels and streams gamma-corrected strip
// words for one column per tick or blank.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  input     push, full, op, led_index .. blue       push && !full
//  result    empty, pop, led_word, last_word         pop && !empty
//  config    cfg_valid, cfg_ready, cfg_index, data   cfg_valid && cfg_ready
//
//  A pixel write goes through the front queue, then one store write.
//  A tick or blank takes the request, then issues the start word, LED words
//  and end word, one word a cycle while the result queue has room, paced by
//  the single read port of the store. A tick that advances the frame then
//  runs the bit-serial frame wrap. The store is not cleared after reset.
//  The result queue holds 4 words; the sequencer stalls when it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module pov_column_led_frame_streamer import povcol_pkg::*; #(
  parameter int MAX_LEDS    = DEF_MAX_LEDS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_FRAMES  = DEF_MAX_FRAMES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            in_op,
  input  logic [4:0]            in_led_index,
  input  logic [5:0]            in_column_index,
  input  logic [2:0]            in_frame_index,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  output logic                  empty,
  input  logic                  pop,
  output logic [31:0]           out_led_word,
  output logic                  out_last_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    q_push, q_full, q_empty, q_pop;
  cmd_t    q_cmd_in, q_cmd_out;
  cfg_wr_t cfg_wr;

  assign full      = q_full;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

  // decode items
  povcol_front #(
    .MAX_LEDS    (MAX_LEDS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_FRAMES  (MAX_FRAMES)
  ) u_front (
    .push         (push),
    .op           (in_op),
    .led_index    (in_led_index),
    .column_index (in_column_index),
    .frame_index  (in_frame_index),
    .red          (in_red),
    .green        (in_green),
    .blue         (in_blue),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd_in)
  );

  // request queue
  povcol_queue #(
    .DEPTH (CMDQ_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_cmd_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd_out),
    .empty (q_empty)
  );

  // store, sequencer and result queue
  povcol_back #(
    .MAX_LEDS    (MAX_LEDS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_FRAMES  (MAX_FRAMES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_wr),
    .cmd_empty     (q_empty),
    .cmd           (q_cmd_out),
    .cmd_pop       (q_pop),
    .out_empty     (empty),
    .out_pop       (pop),
    .out_led_word  (out_led_word),
    .out_last_word (out_last_word)
  );

endmodule

`default_nettype wire

[hdl/povcol_checker.sv]
// ----------------------------------------------------------------------------
// povcol_checker
// Port-level checks on the strip word stream of the POV column streamer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pov_column_led_frame_streamer_assert.svh"

module povcol_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [31:0] out_led_word,
  input logic        out_last_word
);

  logic expect_start_r, expect_start_nxt;
  logic take;

  // track where in a column frame the next shown word falls
  assign take             = pop && !empty;
  assign expect_start_nxt = take ? out_last_word : expect_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_start_r <= 1'b1;
    end else begin
      expect_start_r <= expect_start_nxt;
    end
  end

  `POVCOL_AST_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_led_word) && $stable(out_last_word), "result changed while stalled")

  `POVCOL_AST_NOW(a_end_word, !empty && out_last_word, out_led_word == 32'hFFFF_FFFF, "last word is not all ones")

  `POVCOL_AST_NOW(a_start_word, !empty && expect_start_r, out_led_word == 32'h0 && !out_last_word, "column frame does not open with start word")

  `POVCOL_AST_NOW(a_led_word, !empty && !expect_start_r && !out_last_word, out_led_word[31:24] == 8'hFF, "LED word lacks marker byte")

endmodule

bind pov_column_led_frame_streamer povcol_checker u_povcol_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .empty         (empty),
  .pop           (pop),
  .out_led_word  (out_led_word),
  .out_last_word (out_last_word)
);

`default_nettype wire

[test/pov_column_led_frame_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pov_column_led_frame_checker
// Watches the request, strip word and register channels of the POV column
// streamer. Keeps its own copy of the pixel store, the column, revolution and
// frame counters and the registers. Queues the strip words that each accepted
// request must produce and compares every popped word against the oldest one.
// ----------------------------------------------------------------------------
module pov_column_led_frame_checker import povcol_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  logic [1:0]            in_op,
  input  logic [4:0]            in_led_index,
  input  logic [5:0]            in_column_index,
  input  logic [2:0]            in_frame_index,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [31:0]           out_led_word,
  input  logic                  out_last_word,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam int StoreDepth = DEF_MAX_LEDS * DEF_MAX_COLUMNS * DEF_MAX_FRAMES;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } strip_word_t;

  // pixel copy, {blue, green, red}
  logic [23:0] pixel_mem [StoreDepth];
  strip_word_t words_due [$];
  strip_word_t head_word;

  logic [5:0] led_count_q;
  logic [6:0] column_count_q;
  logic [7:0] revs_per_frame_q;
  logic [3:0] frame_count_q;

  logic [5:0] column_pos;
  logic [7:0] rev_count;
  logic [2:0] frame_pos;

  // gamma: floor(c^3 / 255^2)
  function automatic logic [7:0] gamma_of(input logic [7:0] c);
    int unsigned cube;
    cube = 32'(c);
    cube = cube * cube * cube;
    return 8'(cube / (255 * 255));
  endfunction

  // columns actually in use: zero acts as one, clamp to the store
  function automatic int column_span();
    if (column_count_q == 0) return 1;
    return (column_count_q > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : int'(column_count_q);
  endfunction

  // queue start word, one word per LED and the flagged end word
  task automatic queue_column(input bit dark);
    int          leds;
    int          addr;
    logic [23:0] px;
    strip_word_t w;
    leds = (led_count_q > DEF_MAX_LEDS) ? DEF_MAX_LEDS : int'(led_count_q);
    words_due.push_back('{word: WORD_START, last: 1'b0});
    for (int i = 0; i < leds; i++) begin
      addr = i + column_pos * DEF_MAX_LEDS + frame_pos * DEF_MAX_LEDS * DEF_MAX_COLUMNS;
      px = pixel_mem[addr];
      if (dark) begin
        w.word = {LED_MARK, 24'h000000};
      end else begin
        w.word = {LED_MARK, gamma_of(px[23:16]), gamma_of(px[15:8]), gamma_of(px[7:0])};
      end
      w.last = 1'b0;
      words_due.push_back(w);
    end
    words_due.push_back('{word: WORD_END, last: 1'b1});
  endtask

  // step column down with wrap, count revolutions, advance frame
  task automatic advance_column();
    int span;
    int frames;
    span   = column_span();
    frames = (frame_count_q == 0) ? 1 :
             (frame_count_q > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : int'(frame_count_q);
    if (column_pos == 0 || column_pos >= span) column_pos = 6'(span - 1);
    else column_pos = column_pos - 6'd1;
    if (column_pos == 0) rev_count = rev_count + 8'd1;
    if (rev_count == revs_per_frame_q) begin
      rev_count = 8'd0;
      frame_pos = 3'((frame_pos + 1) % frames);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      led_count_q      = RST_LED_COUNT;
      column_count_q   = RST_COLUMN_COUNT;
      revs_per_frame_q = RST_REVS_PER_FRAME;
      frame_count_q    = RST_FRAME_COUNT;
      column_pos       = 6'(column_span() - 1);
      rev_count        = 8'd0;
      frame_pos        = 3'd0;
      words_due.delete();
      errors           = 0;
    end else begin
      // compare popped word before queuing anything new
      if (pop && !empty) begin
        if (words_due.size() == 0) begin
          $error("led_word: expected none, got %h", out_led_word);
          errors++;
        end else begin
          head_word = words_due.pop_front();
          if (out_led_word !== head_word.word) begin
            $error("led_word: expected %h, got %h", head_word.word, out_led_word);
            errors++;
          end
          if (out_last_word !== head_word.last) begin
            $error("last_word: expected %0d, got %0d", head_word.last, out_last_word);
            errors++;
          end
        end
      end

      // register writes; column count reloads the counters
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LED_COUNT:      led_count_q = cfg_data[5:0];
          REG_COLUMN_COUNT: begin
            column_count_q = cfg_data[6:0];
            column_pos     = 6'(column_span() - 1);
            rev_count      = 8'd0;
            frame_pos      = 3'd0;
          end
          REG_REVS_PER_FRAME: revs_per_frame_q = cfg_data;
          REG_FRAME_COUNT:    frame_count_q = cfg_data[3:0];
          default: ;
        endcase
      end

      // predict accepted request
      if (push && !full) begin
        case (in_op)
          OP_WRITE: pixel_mem[in_led_index + in_column_index * DEF_MAX_LEDS +
                              in_frame_index * DEF_MAX_LEDS * DEF_MAX_COLUMNS] =
                      {in_blue, in_green, in_red};
          OP_TICK: begin
            queue_column(1'b0);
            advance_column();
          end
          OP_BLANK: queue_column(1'b1);
          default: ;
        endcase
      end
    end
    pending = words_due.size();
  end

endmodule

[test/tb_pov_column_led_frame_streamer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pov_column_led_frame_streamer
// Fills the pixel entries that later ticks read, then runs directed requests
// and phases of random write, tick and blank requests under several register
// settings, extremes included, with random stalls on both queue sides. The
// checker beside the block predicts and compares every strip word.
// ----------------------------------------------------------------------------
module tb_pov_column_led_frame_streamer;
  import povcol_pkg::*;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int CYCLE_LIMIT        = 1_000_000;
  localparam int DRAIN_CYCLES       = 64;
  // top columns of frame 0 swept at full LED count, low corner for small counts
  localparam int TOP_COLS           = 3;
  localparam int FILL_COLS          = 3;
  localparam int FILL_LEDS          = 4;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  push            = 1'b0;
  logic                  full;
  logic [1:0]            in_op           = OP_WRITE;
  logic [4:0]            in_led_index    = '0;
  logic [5:0]            in_column_index = '0;
  logic [2:0]            in_frame_index  = '0;
  logic [7:0]            in_red          = '0;
  logic [7:0]            in_green        = '0;
  logic [7:0]            in_blue         = '0;
  logic                  empty;
  logic                  pop             = 1'b0;
  logic [31:0]           out_led_word;
  logic                  out_last_word;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = REG_LED_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  int                    errors;
  int                    pending;
  bit                    calm            = 1'b0;
  int                    cycle_count     = 0;

  pov_column_led_frame_streamer i_dut (.*);

  pov_column_led_frame_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_pov_column_led_frame_streamer: errors");
      $finish;
    end
  end

  // stall the word side at random unless running calm
  always @(negedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= calm || ($urandom_range(0, 99) >= 22);
  end

  // present one request, hold it until accepted
  task automatic send_req(input logic [1:0] op, input logic [4:0] led,
                          input logic [5:0] col, input logic [2:0] frm,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 22) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push            <= 1'b1;
    in_op           <= op;
    in_led_index    <= led;
    in_column_index <= col;
    in_frame_index  <= frm;
    in_red          <= r;
    in_green        <= g;
    in_blue         <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off requests until every expected word is out
  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // write one register once the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // set all registers, then a random mix of requests; ticks past the cap
  // turn into blanks so only filled columns are shown
  task automatic run_phase(input logic [7:0] leds, input logic [7:0] cols,
                           input logic [7:0] revs, input logic [7:0] frames,
                           input int items, input int max_ticks);
    int          sel;
    int          ticks;
    logic [1:0]  op;
    ticks = 0;
    write_reg(REG_LED_COUNT, leds);
    write_reg(REG_COLUMN_COUNT, cols);
    write_reg(REG_REVS_PER_FRAME, revs);
    write_reg(REG_FRAME_COUNT, frames);
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 40) op = OP_WRITE;
      else if (sel < 85) op = OP_TICK;
      else if (sel < 95) op = OP_BLANK;
      else op = OP_SPARE;
      if (op == OP_TICK) begin
        if (ticks >= max_ticks) op = OP_BLANK;
        else ticks++;
      end
      send_req(op, 5'($urandom), 6'($urandom), 3'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fill every pixel that a tick reads
    calm = 1'b1;
    for (int c = DEF_MAX_COLUMNS - TOP_COLS; c < DEF_MAX_COLUMNS; c++) begin
      for (int l = 0; l < DEF_MAX_LEDS; l++) begin
        send_req(OP_WRITE, 5'(l), 6'(c), 3'd0, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    for (int f = 0; f < DEF_MAX_FRAMES; f++) begin
      for (int c = 0; c < FILL_COLS; c++) begin
        for (int l = 0; l < FILL_LEDS; l++) begin
          send_req(OP_WRITE, 5'(l), 6'(c), 3'(f), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    calm = 1'b0;

    // color extremes on the first column shown after reset
    send_req(OP_WRITE, 5'd0, 6'd63, 3'd0, 8'h00, 8'h00, 8'h00);
    send_req(OP_WRITE, 5'd31, 6'd63, 3'd0, 8'hFF, 8'hFF, 8'hFF);
    send_req(OP_WRITE, 5'd1, 6'd63, 3'd0, 8'hFF, 8'h00, 8'h00);
    send_req(OP_WRITE, 5'd2, 6'd63, 3'd0, 8'h00, 8'h80, 8'h01);
    send_req(OP_WRITE, 5'd3, 6'd62, 3'd0, 8'h01, 8'hFE, 8'h7F);
    send_req(OP_TICK, 5'd0, 6'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_req(OP_BLANK, 5'h1F, 6'h3F, 3'h7, 8'hFF, 8'hFF, 8'hFF);
    // unused op must be dropped
    send_req(OP_SPARE, 5'h1F, 6'h3F, 3'h7, 8'hFF, 8'hFF, 8'hFF);
    send_req(OP_WRITE, 5'd31, 6'd63, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    send_req(OP_TICK, 5'h1F, 6'h3F, 3'h7, 8'hFF, 8'hFF, 8'hFF);
    send_req(OP_WRITE, 5'd0, 6'd0, 3'd0, 8'hFE, 8'h02, 8'h64);
    send_req(OP_BLANK, 5'd0, 6'd0, 3'd0, 8'h00, 8'h00, 8'h00);
    send_req(OP_TICK, 5'd0, 6'd0, 3'd0, 8'h00, 8'h00, 8'h00);

    // one column: every tick wraps and advances the frame
    run_phase(8'd1, 8'd1, 8'd1, 8'd8, 12, 12);
    // zero everywhere: framing only, clamped counts, literal zero revs
    run_phase(8'd0, 8'd0, 8'd0, 8'd0, 8, 8);
    // all ones: counts clamp to the store, no random stalls
    calm = 1'b1;
    run_phase(8'hFF, 8'hFF, 8'hFF, 8'hFF, 10, TOP_COLS);
    calm = 1'b0;
    run_phase(8'd4, 8'd3, 8'd2, 8'd3, 16, 16);
    run_phase(8'd2, 8'd2, 8'd0, 8'd5, 12, 12);
    for (int p = 0; p < 3; p++) begin
      run_phase(8'($urandom_range(1, FILL_LEDS)), 8'($urandom_range(1, FILL_COLS)),
                8'($urandom_range(1, 3)), 8'($urandom_range(1, 8)), 14, 14);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_pov_column_led_frame_streamer: clean");
    end else begin
      $display("tb_pov_column_led_frame_streamer: errors");
    end
    $finish;
  end

endmodule
